// ===== rtl/ttf_pkg.sv =====
package ttf_pkg;

  // Default field layouts.
  localparam int POSITION_BITS_DEF = 20;
  localparam int UV_BITS_DEF       = 16;
  localparam int FRAME_BITS_DEF    = 16;

  localparam int POS_FIELD_W = 60;
  localparam int UV_FIELD_W  = 32;
  localparam int VEC_FIELD_W = 48;
  localparam int CFG_W       = 16;

  // Zero-extended views wide enough for the largest parameter values.
  localparam int POS_EXT_W = 64;
  localparam int UV_EXT_W  = 48;

  localparam logic [CFG_W-1:0] FLAT_THRESHOLD_RESET = 16'd17;

  // Normalizer internals: the largest magnitude is scaled into [2^29, 2^30).
  localparam int NORM_W  = 64;
  localparam int SCALE_W = 30;
  localparam int LS_W    = 2 * SCALE_W + 2;
  localparam int ROOT_W  = 31;

  typedef struct packed {
    logic [POS_FIELD_W-1:0] first_position;
    logic [POS_FIELD_W-1:0] second_position;
    logic [POS_FIELD_W-1:0] third_position;
    logic [UV_FIELD_W-1:0]  first_uv;
    logic [UV_FIELD_W-1:0]  second_uv;
    logic [UV_FIELD_W-1:0]  third_uv;
  } in_item_t;

  typedef struct packed {
    logic [VEC_FIELD_W-1:0] face_normal;
    logic [VEC_FIELD_W-1:0] face_tangent;
    logic [VEC_FIELD_W-1:0] face_bitangent;
    logic                   flat_mapping;
    logic                   zero_length;
  } out_item_t;

  // Pipeline stages from a vector entering the normalizer to its unit vector:
  // magnitude, two shift stages, squares, sum, square root, divider setup,
  // one divider stage per quotient bit, sign.
  function automatic int norm_latency(input int frac);
    norm_latency = 5 + ROOT_W + 1 + (frac + 1) + 1;
  endfunction

endpackage

// ===== rtl/ttf_norm.sv =====
module ttf_norm #(
  parameter int VEC_W = 48,
  parameter int FRAC  = 14
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0][VEC_W-1:0] vec_in,
  output logic [2:0][FRAC+1:0]  unit_out,
  output logic                  zero_out
);
  import ttf_pkg::*;

  localparam int QW     = FRAC + 1;
  localparam int RW     = ROOT_W + FRAC + 1;
  localparam int NDIV   = FRAC + 1;
  localparam int TRY_W  = LS_W + 2;

  // Magnitudes and the largest one.
  logic [2:0][VEC_W-1:0] mag1_r;
  logic [VEC_W-1:0]      max1_r;
  logic [2:0]            sgn1_r;
  logic                  zero1_r;
  logic [2:0][VEC_W-1:0] mag_nxt;
  logic [VEC_W-1:0]      max_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = vec_in[i][VEC_W-1] ? (VEC_W'(0) - vec_in[i]) : vec_in[i];
    end
    max_nxt = mag_nxt[0];
    if (mag_nxt[1] > max_nxt) max_nxt = mag_nxt[1];
    if (mag_nxt[2] > max_nxt) max_nxt = mag_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag_nxt;
      max1_r  <= max_nxt;
      zero1_r <= (max_nxt == '0);
      for (int i = 0; i < 3; i++) sgn1_r[i] <= vec_in[i][VEC_W-1];
    end
  end

  // Left-justify the largest magnitude in two stages of three shift steps.
  logic [NORM_W-1:0]      m2_nxt;
  logic [2:0][NORM_W-1:0] x2_nxt;
  logic [NORM_W-1:0]      m2_r;
  logic [2:0][NORM_W-1:0] x2_r;
  logic [2:0]             sgn2_r;
  logic                   zero2_r;

  always_comb begin
    m2_nxt = NORM_W'(max1_r);
    for (int i = 0; i < 3; i++) x2_nxt[i] = NORM_W'(mag1_r[i]);
    for (int s = 5; s >= 3; s--) begin
      if (m2_nxt < (NORM_W'(1) << (NORM_W - (1 << s)))) begin
        m2_nxt = m2_nxt << (1 << s);
        for (int i = 0; i < 3; i++) x2_nxt[i] = x2_nxt[i] << (1 << s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r    <= m2_nxt;
      x2_r    <= x2_nxt;
      sgn2_r  <= sgn1_r;
      zero2_r <= zero1_r;
    end
  end

  logic [NORM_W-1:0]       m3_nxt;
  logic [2:0][NORM_W-1:0]  x3_nxt;
  logic [2:0][SCALE_W-1:0] a3_r;
  logic [2:0]              sgn3_r;
  logic                    zero3_r;

  always_comb begin
    m3_nxt = m2_r;
    x3_nxt = x2_r;
    for (int s = 2; s >= 0; s--) begin
      if (m3_nxt < (NORM_W'(1) << (NORM_W - (1 << s)))) begin
        m3_nxt = m3_nxt << (1 << s);
        for (int i = 0; i < 3; i++) x3_nxt[i] = x3_nxt[i] << (1 << s);
      end
    end
  end

  // Taking the top bits truncates exactly like a right shift of the scaled value.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a3_r[i] <= x3_nxt[i][NORM_W-1 -: SCALE_W];
      sgn3_r  <= sgn2_r;
      zero3_r <= zero2_r;
    end
  end

  // Squares, then their sum.
  logic [2:0][2*SCALE_W-1:0] sq4_r;
  logic [2:0][SCALE_W-1:0]   a4_r;
  logic [2:0]                sgn4_r;
  logic                      zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq4_r[i] <= a3_r[i] * a3_r[i];
      a4_r    <= a3_r;
      sgn4_r  <= sgn3_r;
      zero4_r <= zero3_r;
    end
  end

  // Square root, one result bit per stage. Stage 0 holds the sum of squares.
  logic [LS_W-1:0]         rem_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0]       root_r [0:ROOT_W];
  logic [2:0][SCALE_W-1:0] sa_r   [0:ROOT_W];
  logic [2:0]              ssg_r  [0:ROOT_W];
  logic                    sz_r   [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= LS_W'(sq4_r[0]) + LS_W'(sq4_r[1]) + LS_W'(sq4_r[2]);
      root_r[0] <= '0;
      sa_r[0]   <= a4_r;
      ssg_r[0]  <= sgn4_r;
      sz_r[0]   <= zero4_r;
    end
  end

  for (genvar j = 1; j <= ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - j;
    logic [TRY_W-1:0] trial;
    logic             take;

    assign trial = (TRY_W'(root_r[j-1]) << (B + 1)) + (TRY_W'(1) << (2 * B));
    assign take  = TRY_W'(rem_r[j-1]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= take ? (root_r[j-1] | (ROOT_W'(1) << B)) : root_r[j-1];
        sa_r[j]   <= sa_r[j-1];
        ssg_r[j]  <= ssg_r[j-1];
        sz_r[j]   <= sz_r[j-1];
      end
    end

    if (j < ROOT_W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= take ? LS_W'(TRY_W'(rem_r[j-1]) - trial) : rem_r[j-1];
        end
      end
    end
  end

  // Rounded division of each scaled magnitude by the length, one quotient
  // bit per stage. Stage 0 holds the numerators.
  logic [2:0][RW-1:0] drem_r [0:NDIV-1];
  logic [2:0][QW-1:0] q_r    [0:NDIV];
  logic [ROOT_W-1:0]  len_r  [0:NDIV];
  logic [2:0]         dsg_r  [0:NDIV];
  logic               dz_r   [0:NDIV];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= (RW'(sa_r[ROOT_W][i]) << FRAC) + RW'(root_r[ROOT_W] >> 1);
      end
      q_r[0]   <= '0;
      len_r[0] <= root_r[ROOT_W];
      dsg_r[0] <= ssg_r[ROOT_W];
      dz_r[0]  <= sz_r[ROOT_W];
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int K = NDIV - j;
    logic [RW-1:0] dvs;
    logic [2:0]    take;

    assign dvs = RW'(len_r[j-1]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) take[i] = drem_r[j-1][i] >= dvs;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          q_r[j][i] <= take[i] ? (q_r[j-1][i] | (QW'(1) << K)) : q_r[j-1][i];
        end
        len_r[j] <= len_r[j-1];
        dsg_r[j] <= dsg_r[j-1];
        dz_r[j]  <= dz_r[j-1];
      end
    end

    if (j < NDIV) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            drem_r[j][i] <= take[i] ? (drem_r[j-1][i] - dvs) : drem_r[j-1][i];
          end
        end
      end
    end
  end

  logic [2:0][FRAC+1:0] unit_r;
  logic                 zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dz_r[NDIV]) begin
          unit_r[i] <= '0;
        end else if (dsg_r[NDIV][i]) begin
          unit_r[i] <= (FRAC + 2)'(0) - (FRAC + 2)'(q_r[NDIV][i]);
        end else begin
          unit_r[i] <= (FRAC + 2)'(q_r[NDIV][i]);
        end
      end
      zero_r <= dz_r[NDIV];
    end
  end

  assign unit_out = unit_r;
  assign zero_out = zero_r;

endmodule

// ===== rtl/triangle_tangent_frame_core.sv =====
// Per-triangle tangent frame. Each transfer on the input channel carries one
// triangle and produces exactly one result transfer: the unit face normal, the
// unit tangent and the sign-corrected bitangent in Q1.14, plus the flat-mapping
// and zero-length flags. The pipeline takes a new triangle every cycle while the
// output is not stalled; the normalizers hold a 31-stage square root and a
// divider with one stage per quotient bit. The whole pipeline holds while a
// result waits on a stalled output. flat_threshold is written on the cfg
// channel, which is always ready; write it only while no triangle is in flight.
module triangle_tangent_frame_core #(
  parameter int POSITION_BITS = ttf_pkg::POSITION_BITS_DEF,
  parameter int UV_BITS       = ttf_pkg::UV_BITS_DEF,
  parameter int FRAME_BITS    = ttf_pkg::FRAME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ttf_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ttf_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ttf_pkg::CFG_W-1:0] cfg_data
);
  import ttf_pkg::*;

  localparam int P    = POSITION_BITS;
  localparam int U    = UV_BITS;
  localparam int FB   = FRAME_BITS;
  localparam int F    = FB - 2;
  localparam int EW   = P + 1;
  localparam int DW   = U + 1;
  localparam int CW   = 2 * EW + 1;
  localparam int DETW = 2 * DW + 1;
  localparam int TW   = EW + DW + 1;
  localparam int VW   = (CW > TW) ? CW : TW;
  localparam int NL   = norm_latency(F);
  localparam int CXW  = 2 * FB + 1;
  localparam int DOTW = 2 * FB + 2;

  localparam logic signed [FB-1:0]  ONE  = FB'(1) << F;
  localparam logic [CXW-1:0]        HALF = CXW'(1) << (F - 1);
  localparam logic [CXW-1:0]        LIM  = (CXW'(1) << (FB - 1)) - CXW'(1);

  logic en;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  logic [CFG_W-1:0] thr_r;

  // Valid bits of every stage.
  logic          v1_r, v2_r, v3_r, v4_r, x1_v_r, x2_v_r, x3_v_r, out_valid_r;
  logic [NL-1:0] dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= FLAT_THRESHOLD_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      dv_r        <= '0;
      x1_v_r      <= 1'b0;
      x2_v_r      <= 1'b0;
      x3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
      if (en) begin
        v1_r        <= in_valid;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        dv_r        <= {dv_r[NL-2:0], v4_r};
        x1_v_r      <= dv_r[NL-1];
        x2_v_r      <= x1_v_r;
        x3_v_r      <= x2_v_r;
        out_valid_r <= x3_v_r;
      end
    end
  end

  // Stage 1: edges and uv deltas.
  logic [POS_EXT_W-1:0]   pw0, pw1, pw2;
  logic [UV_EXT_W-1:0]    uw0, uw1, uw2;
  logic signed [EW-1:0]   e1_nxt [3];
  logic signed [EW-1:0]   e2_nxt [3];
  logic signed [EW-1:0]   e1_r   [3];
  logic signed [EW-1:0]   e2_r   [3];
  logic signed [DW-1:0]   du1_r, dv1_r, du2_r, dv2_r;

  assign pw0 = POS_EXT_W'(in_data.first_position);
  assign pw1 = POS_EXT_W'(in_data.second_position);
  assign pw2 = POS_EXT_W'(in_data.third_position);
  assign uw0 = UV_EXT_W'(in_data.first_uv);
  assign uw1 = UV_EXT_W'(in_data.second_uv);
  assign uw2 = UV_EXT_W'(in_data.third_uv);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e1_nxt[j] = EW'($signed(pw1[j*P +: P])) - EW'($signed(pw0[j*P +: P]));
      e2_nxt[j] = EW'($signed(pw2[j*P +: P])) - EW'($signed(pw0[j*P +: P]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r  <= e1_nxt;
      e2_r  <= e2_nxt;
      du1_r <= DW'($signed(uw1[U-1:0])) - DW'($signed(uw0[U-1:0]));
      dv1_r <= DW'($signed(uw1[2*U-1:U])) - DW'($signed(uw0[2*U-1:U]));
      du2_r <= DW'($signed(uw2[U-1:0])) - DW'($signed(uw0[U-1:0]));
      dv2_r <= DW'($signed(uw2[2*U-1:U])) - DW'($signed(uw0[2*U-1:U]));
    end
  end

  // Stage 2: all products.
  logic signed [2*EW-1:0]  pc_r [6];
  logic signed [2*DW-1:0]  pd_r [2];
  logic signed [EW+DW-1:0] pt_r [6];
  logic signed [EW+DW-1:0] pb_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0] <= e1_r[1] * e2_r[2];
      pc_r[1] <= e1_r[2] * e2_r[1];
      pc_r[2] <= e1_r[2] * e2_r[0];
      pc_r[3] <= e1_r[0] * e2_r[2];
      pc_r[4] <= e1_r[0] * e2_r[1];
      pc_r[5] <= e1_r[1] * e2_r[0];
      pd_r[0] <= du1_r * dv2_r;
      pd_r[1] <= dv1_r * du2_r;
      for (int j = 0; j < 3; j++) begin
        pt_r[2*j]   <= e1_r[j] * dv2_r;
        pt_r[2*j+1] <= e2_r[j] * dv1_r;
        pb_r[2*j]   <= e2_r[j] * du1_r;
        pb_r[2*j+1] <= e1_r[j] * du2_r;
      end
    end
  end

  // Stage 3: differences.
  logic signed [CW-1:0]   c3_r [3];
  logic signed [TW-1:0]   t3_r [3];
  logic signed [TW-1:0]   b3_r [3];
  logic signed [DETW-1:0] det3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        c3_r[j] <= CW'(pc_r[2*j]) - CW'(pc_r[2*j+1]);
        t3_r[j] <= TW'(pt_r[2*j]) - TW'(pt_r[2*j+1]);
        b3_r[j] <= TW'(pb_r[2*j]) - TW'(pb_r[2*j+1]);
      end
      det3_r <= DETW'(pd_r[0]) - DETW'(pd_r[1]);
    end
  end

  // Stage 4: flat test and orientation of tangent and binormal.
  logic [DETW-1:0]    det_mag;
  logic [2:0][VW-1:0] nvec_r, tvec_r, bvec_r;
  logic               flat4_r;

  assign det_mag = det3_r[DETW-1] ? (DETW'(0) - DETW'(det3_r)) : DETW'(det3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      flat4_r <= det_mag < DETW'(thr_r);
      for (int j = 0; j < 3; j++) begin
        nvec_r[j] <= VW'(c3_r[j]);
        tvec_r[j] <= det3_r[DETW-1] ? VW'(-t3_r[j]) : VW'(t3_r[j]);
        bvec_r[j] <= det3_r[DETW-1] ? VW'(-b3_r[j]) : VW'(b3_r[j]);
      end
    end
  end

  // Normalizers.
  logic [2:0][FB-1:0] nrm_u, tan_u, bin_u;
  logic               nrm_z, tan_z, bin_z;

  ttf_norm #(.VEC_W(VW), .FRAC(F)) u_norm_n (
    .clk(clk), .en(en), .vec_in(nvec_r), .unit_out(nrm_u), .zero_out(nrm_z)
  );
  ttf_norm #(.VEC_W(VW), .FRAC(F)) u_norm_t (
    .clk(clk), .en(en), .vec_in(tvec_r), .unit_out(tan_u), .zero_out(tan_z)
  );
  ttf_norm #(.VEC_W(VW), .FRAC(F)) u_norm_b (
    .clk(clk), .en(en), .vec_in(bvec_r), .unit_out(bin_u), .zero_out(bin_z)
  );

  logic [NL-1:0] dflat_r;

  always_ff @(posedge clk) begin
    if (en) dflat_r <= {dflat_r[NL-2:0], flat4_r};
  end

  // X1: frame select and normal x tangent products.
  logic               flat_d;
  logic signed [FB-1:0] tsel [3];
  logic signed [FB-1:0] bsel [3];
  logic signed [FB-1:0] nrm1_r [3];
  logic signed [FB-1:0] tan1_r [3];
  logic signed [FB-1:0] bin1_r [3];
  logic signed [2*FB-1:0] px1_r [6];
  logic                 flat1_r, zero1_r;

  assign flat_d = dflat_r[NL-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tsel[j] = $signed(tan_u[j]);
      bsel[j] = $signed(bin_u[j]);
    end
    if (flat_d) begin
      tsel[0] = ONE;
      tsel[1] = '0;
      tsel[2] = '0;
      bsel[0] = '0;
      bsel[1] = '0;
      bsel[2] = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        nrm1_r[j] <= $signed(nrm_u[j]);
        tan1_r[j] <= tsel[j];
        bin1_r[j] <= bsel[j];
      end
      px1_r[0] <= $signed(nrm_u[1]) * tsel[2];
      px1_r[1] <= $signed(nrm_u[2]) * tsel[1];
      px1_r[2] <= $signed(nrm_u[2]) * tsel[0];
      px1_r[3] <= $signed(nrm_u[0]) * tsel[2];
      px1_r[4] <= $signed(nrm_u[0]) * tsel[1];
      px1_r[5] <= $signed(nrm_u[1]) * tsel[0];
      flat1_r  <= flat_d;
      zero1_r  <= nrm_z || (!flat_d && (tan_z || bin_z));
    end
  end

  // X2: cross product, rounded half away from zero and saturated.
  logic signed [CXW-1:0] cx   [3];
  logic [CXW-1:0]        cmag [3];
  logic [CXW-1:0]        qr   [3];
  logic signed [FB-1:0]  bit2_nxt [3];
  logic signed [FB-1:0]  bit2_r [3];
  logic signed [FB-1:0]  nrm2_r [3];
  logic signed [FB-1:0]  tan2_r [3];
  logic signed [FB-1:0]  bin2_r [3];
  logic                  flat2_r, zero2_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cx[j]   = CXW'(px1_r[2*j]) - CXW'(px1_r[2*j+1]);
      cmag[j] = cx[j][CXW-1] ? (CXW'(0) - CXW'(cx[j])) : CXW'(cx[j]);
      qr[j]   = (cmag[j] + HALF) >> F;
      if (qr[j] > LIM) qr[j] = LIM;
      bit2_nxt[j] = cx[j][CXW-1] ? (FB'(0) - FB'(qr[j])) : FB'(qr[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bit2_r  <= bit2_nxt;
      nrm2_r  <= nrm1_r;
      tan2_r  <= tan1_r;
      bin2_r  <= bin1_r;
      flat2_r <= flat1_r;
      zero2_r <= zero1_r;
    end
  end

  // X3: bitangent . binormal products.
  logic signed [2*FB-1:0] pdot3_r [3];
  logic signed [FB-1:0]   bit3_r  [3];
  logic signed [FB-1:0]   nrm3_r  [3];
  logic signed [FB-1:0]   tan3_r  [3];
  logic                   flat3_r, zero3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) pdot3_r[j] <= bit2_r[j] * bin2_r[j];
      bit3_r  <= bit2_r;
      nrm3_r  <= nrm2_r;
      tan3_r  <= tan2_r;
      flat3_r <= flat2_r;
      zero3_r <= zero2_r;
    end
  end

  // Output register: flip the bitangent when it opposes the binormal.
  logic signed [DOTW-1:0] dot;
  logic [3*FB-1:0]        nrm_pk, tan_pk, bit_pk;
  logic [FB-1:0]          bit_fin [3];
  out_item_t              out_r;

  assign dot = DOTW'(pdot3_r[0]) + DOTW'(pdot3_r[1]) + DOTW'(pdot3_r[2]);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      bit_fin[j] = dot[DOTW-1] ? (FB'(0) - FB'(bit3_r[j])) : FB'(bit3_r[j]);
    end
    nrm_pk = {nrm3_r[2], nrm3_r[1], nrm3_r[0]};
    tan_pk = {tan3_r[2], tan3_r[1], tan3_r[0]};
    bit_pk = {bit_fin[2], bit_fin[1], bit_fin[0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.face_normal    <= VEC_FIELD_W'(nrm_pk);
      out_r.face_tangent   <= VEC_FIELD_W'(tan_pk);
      out_r.face_bitangent <= VEC_FIELD_W'(bit_pk);
      out_r.flat_mapping   <= flat3_r;
      out_r.zero_length    <= zero3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
